// File: sv/ctr_pkg.sv
`timescale 1ns / 1ps
package ctr_pkg;

    // Datapath width: coordinates are scaled so their magnitude sits at
    // bit SCALE_MSB - 1, leaving headroom for the CORDIC growth.
    localparam int SCALE_MSB = 59;
    localparam int DATA_W    = 62;

    // Inverse CORDIC gain in Q32, and 1/(2*pi) in Q64.
    localparam logic [31:0] INV_GAIN   = 32'h9B74EDA8;
    localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

    // Side flags that ride along with each word.
    typedef struct packed {
        logic on_axis;   // x and y both zero
        logic z_zero;
        logic z_neg;
    } t_flags;

    // Restoring long division, used only while building the table.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mul_hi64(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[127:64];
    endfunction

    // atan(2^-idx) in Q62 radians from its power series (idx >= 1).
    function automatic logic [63:0] atan_q62(int unsigned idx);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned e;
        int unsigned k;
        sum = '0;
        for (k = 0; k < 64; k++) begin
            e = idx * (2 * k + 1);
            if (e < 62) begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Arctangent table entry in binary angle units, 2^aw per full turn.
    function automatic logic [63:0] atan_entry(int unsigned idx, int unsigned aw);
        logic [63:0] turns;
        if (idx == 0)
            return 64'd1 << (aw - 3);
        turns = mul_hi64(atan_q62(idx), INV_TWO_PI);
        return (turns + (64'd1 << (61 - aw))) >> (62 - aw);
    endfunction

endpackage

// File: sv/ctr_cell.sv
`timescale 1ns / 1ps
module ctr_cell #(
    parameter int                 DATA_W  = 62,
    parameter int                 ANGLE_W = 32,
    parameter int                 SIDE_W  = 32,
    parameter int                 STAGE   = 0,
    parameter logic [ANGLE_W-1:0] ATAN    = '0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [DATA_W-1:0]   i_x,
    input  logic signed [DATA_W-1:0]   i_y,
    input  logic        [ANGLE_W-1:0]  i_ang,
    input  logic        [SIDE_W-1:0]   i_side,
    input  ctr_pkg::t_flags            i_flags,
    output logic                       o_valid,
    output logic signed [DATA_W-1:0]   o_x,
    output logic signed [DATA_W-1:0]   o_y,
    output logic        [ANGLE_W-1:0]  o_ang,
    output logic        [SIDE_W-1:0]   o_side,
    output ctr_pkg::t_flags            o_flags
);
    import ctr_pkg::*;

    logic                      r_valid;
    logic signed [DATA_W-1:0]  r_x, r_y, n_x, n_y;
    logic        [ANGLE_W-1:0] r_ang, n_ang;
    logic        [SIDE_W-1:0]  r_side;
    t_flags                    r_flags;
    logic signed [DATA_W-1:0]  w_xs, w_ys;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    // Rotate toward y = 0 and track the angle turned.
    always_comb begin
        if (!i_y[DATA_W-1]) begin
            n_x   = i_x + w_ys;
            n_y   = i_y - w_xs;
            n_ang = i_ang + ATAN;
        end else begin
            n_x   = i_x - w_ys;
            n_y   = i_y + w_xs;
            n_ang = i_ang - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_ang   <= n_ang;
            r_side  <= i_side;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_ang   = r_ang;
    assign o_side  = r_side;
    assign o_flags = r_flags;

endmodule

// File: sv/ctr_gain.sv
`timescale 1ns / 1ps
module ctr_gain #(
    parameter int ANGLE_W = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [ctr_pkg::DATA_W-1:0] i_mag,
    input  logic signed [ctr_pkg::DATA_W-1:0] i_z,
    input  logic        [ANGLE_W-1:0]        i_ra,
    input  ctr_pkg::t_flags                  i_flags,
    output logic                             o_valid,
    output logic signed [ctr_pkg::DATA_W-1:0] o_mag,
    output logic signed [ctr_pkg::DATA_W-1:0] o_z,
    output logic        [ANGLE_W-1:0]        o_ra,
    output ctr_pkg::t_flags                  o_flags
);
    import ctr_pkg::*;

    localparam int HI_W = DATA_W - 32;

    // Stage A: split the magnitude and multiply both halves.
    logic                     r_va;
    logic [DATA_W-1:0]        r_hi;
    logic [63:0]              r_lo;
    logic signed [DATA_W-1:0] r_za;
    logic [ANGLE_W-1:0]       r_raa;
    t_flags                   r_fa;

    // Stage B: add the partial products.
    logic                     r_vb;
    logic signed [DATA_W-1:0] r_mag;
    logic signed [DATA_W-1:0] r_zb;
    logic [ANGLE_W-1:0]       r_rab;
    t_flags                   r_fb;
    logic [DATA_W-1:0]        n_mag;

    assign n_mag = r_hi + DATA_W'(r_lo[63:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi  <= {{32{1'b0}}, i_mag[DATA_W-1:32]} * {{HI_W{1'b0}}, INV_GAIN};
            r_lo  <= {32'd0, i_mag[31:0]} * {32'd0, INV_GAIN};
            r_za  <= i_z;
            r_raa <= i_ra;
            r_fa  <= i_flags;
            r_mag <= signed'(n_mag);
            r_zb  <= r_za;
            r_rab <= r_raa;
            r_fb  <= r_fa;
        end
    end

    assign o_valid = r_vb;
    assign o_mag   = r_mag;
    assign o_z     = r_zb;
    assign o_ra    = r_rab;
    assign o_flags = r_fb;

endmodule

// File: sv/cartesian_to_radec.sv
`timescale 1ns / 1ps
// Cartesian (x, y, z) to right ascension / declination converter.
//
// Input channel: i_valid with i_x_coord, i_y_coord, i_z_coord; a word is
// taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid with o_ra_angle, o_dec_angle; a word leaves at an
// edge where o_valid is high and i_stall is low.
// Angles are binary: 2^ANGLE_WIDTH units per turn, RA in [0, 360),
// Dec signed with 2^(ANGLE_WIDTH-2) meaning +90 degrees.
//
// Throughput: one vector per clock while the receiver does not stall. The
// path runs through one input register, a row of CORDIC cells for the
// RA pass, two gain-multiply stages, a second row of cells for the Dec
// pass and the output register.
// When the receiver stalls with a word waiting, the whole row of cells
// holds and o_stall rises in the same cycle; bubbles stay in place.
// Reset (synchronous, active low) clears every valid bit; data registers
// keep whatever they held and are ignored until refilled.
module cartesian_to_radec #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic        [ANGLE_WIDTH-1:0] o_ra_angle,
    output logic signed [ANGLE_WIDTH-1:0] o_dec_angle
);
    import ctr_pkg::*;

    localparam int GUARD = SCALE_MSB - COORD_WIDTH;
    localparam int S     = CORDIC_STAGES;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
    localparam logic signed [ANGLE_WIDTH-1:0] QUARTER =
        ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH-1:0] NEG_QUARTER = -QUARTER;

    // Whole pipeline advances unless the output word is held by the receiver.
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // ---------------------------------------------------------------
    // Input stage: scale up, fold the left half-plane, flag special cases.
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0]  w_xs, w_ys, w_zs;
    logic signed [DATA_W-1:0]  n_px, n_py;
    logic        [ANGLE_WIDTH-1:0] n_pang;
    t_flags                    n_pflags;

    logic                      r_p_valid;
    logic signed [DATA_W-1:0]  r_px, r_py, r_pz;
    logic        [ANGLE_WIDTH-1:0] r_pang;
    t_flags                    r_pflags;

    assign w_xs = DATA_W'(i_x_coord) <<< GUARD;
    assign w_ys = DATA_W'(i_y_coord) <<< GUARD;
    assign w_zs = DATA_W'(i_z_coord) <<< GUARD;

    always_comb begin
        if (i_x_coord[COORD_WIDTH-1]) begin
            // Turn by a half turn so the vector lands in the right half-plane.
            n_px   = -w_xs;
            n_py   = -w_ys;
            n_pang = HALF_TURN;
        end else begin
            n_px   = w_xs;
            n_py   = w_ys;
            n_pang = '0;
        end
        n_pflags.on_axis = (i_x_coord == '0) && (i_y_coord == '0);
        n_pflags.z_zero  = (i_z_coord == '0);
        n_pflags.z_neg   = i_z_coord[COORD_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px     <= n_px;
            r_py     <= n_py;
            r_pz     <= w_zs;
            r_pang   <= n_pang;
            r_pflags <= n_pflags;
        end
    end

    // ---------------------------------------------------------------
    // RA pass: atan2(y, x), z rides along in the side band.
    // ---------------------------------------------------------------
    logic                         w_v1 [S+1];
    logic signed [DATA_W-1:0]     w_x1 [S+1];
    logic signed [DATA_W-1:0]     w_y1 [S+1];
    logic        [ANGLE_WIDTH-1:0] w_a1 [S+1];
    logic        [DATA_W-1:0]     w_s1 [S+1];
    t_flags                       w_f1 [S+1];

    assign w_v1[0] = r_p_valid;
    assign w_x1[0] = r_px;
    assign w_y1[0] = r_py;
    assign w_a1[0] = r_pang;
    assign w_s1[0] = r_pz;
    assign w_f1[0] = r_pflags;

    for (genvar i = 0; i < S; i++) begin : g_ra
        localparam logic [63:0] ATAN_FULL = atan_entry(i, ANGLE_WIDTH);
        ctr_cell #(
            .DATA_W  (DATA_W),
            .ANGLE_W (ANGLE_WIDTH),
            .SIDE_W  (DATA_W),
            .STAGE   (i),
            .ATAN    (ATAN_FULL[ANGLE_WIDTH-1:0])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v1[i]),
            .i_x     (w_x1[i]),
            .i_y     (w_y1[i]),
            .i_ang   (w_a1[i]),
            .i_side  (w_s1[i]),
            .i_flags (w_f1[i]),
            .o_valid (w_v1[i+1]),
            .o_x     (w_x1[i+1]),
            .o_y     (w_y1[i+1]),
            .o_ang   (w_a1[i+1]),
            .o_side  (w_s1[i+1]),
            .o_flags (w_f1[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Gain correction of the (x, y) magnitude.
    // ---------------------------------------------------------------
    logic                         w_gv;
    logic signed [DATA_W-1:0]     w_gmag, w_gz;
    logic        [ANGLE_WIDTH-1:0] w_gra;
    t_flags                       w_gf;

    ctr_gain #(
        .ANGLE_W (ANGLE_WIDTH)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1[S]),
        .i_mag   (w_x1[S]),
        .i_z     (signed'(w_s1[S])),
        .i_ra    (w_a1[S]),
        .i_flags (w_f1[S]),
        .o_valid (w_gv),
        .o_mag   (w_gmag),
        .o_z     (w_gz),
        .o_ra    (w_gra),
        .o_flags (w_gf)
    );

    // ---------------------------------------------------------------
    // Dec pass: atan2(z, |xy|), RA rides along in the side band.
    // ---------------------------------------------------------------
    logic                         w_v2 [S+1];
    logic signed [DATA_W-1:0]     w_x2 [S+1];
    logic signed [DATA_W-1:0]     w_y2 [S+1];
    logic        [ANGLE_WIDTH-1:0] w_a2 [S+1];
    logic        [ANGLE_WIDTH-1:0] w_s2 [S+1];
    t_flags                       w_f2 [S+1];

    assign w_v2[0] = w_gv;
    assign w_x2[0] = w_gmag;
    assign w_y2[0] = w_gz;
    assign w_a2[0] = '0;
    assign w_s2[0] = w_gra;
    assign w_f2[0] = w_gf;

    for (genvar i = 0; i < S; i++) begin : g_dec
        localparam logic [63:0] ATAN_FULL = atan_entry(i, ANGLE_WIDTH);
        ctr_cell #(
            .DATA_W  (DATA_W),
            .ANGLE_W (ANGLE_WIDTH),
            .SIDE_W  (ANGLE_WIDTH),
            .STAGE   (i),
            .ATAN    (ATAN_FULL[ANGLE_WIDTH-1:0])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v2[i]),
            .i_x     (w_x2[i]),
            .i_y     (w_y2[i]),
            .i_ang   (w_a2[i]),
            .i_side  (w_s2[i]),
            .i_flags (w_f2[i]),
            .o_valid (w_v2[i+1]),
            .o_x     (w_x2[i+1]),
            .o_y     (w_y2[i+1]),
            .o_ang   (w_a2[i+1]),
            .o_side  (w_s2[i+1]),
            .o_flags (w_f2[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Output register: clamp Dec and apply the on-axis cases.
    // ---------------------------------------------------------------
    logic signed [ANGLE_WIDTH-1:0] w_sd;
    logic        [ANGLE_WIDTH-1:0] n_ra;
    logic signed [ANGLE_WIDTH-1:0] n_dec;
    logic                          r_out_valid;
    logic        [ANGLE_WIDTH-1:0] r_ra;
    logic signed [ANGLE_WIDTH-1:0] r_dec;

    assign w_sd = signed'(w_a2[S]);

    always_comb begin
        if (w_f2[S].on_axis) begin
            // On the pole axis, or the zero vector: no CORDIC result is used.
            n_ra = '0;
            if (w_f2[S].z_zero)
                n_dec = '0;
            else if (w_f2[S].z_neg)
                n_dec = NEG_QUARTER;
            else
                n_dec = QUARTER;
        end else begin
            n_ra = w_s2[S];
            if (w_sd > QUARTER)
                n_dec = QUARTER;
            else if (w_sd < NEG_QUARTER)
                n_dec = NEG_QUARTER;
            else
                n_dec = w_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v2[S];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ra  <= n_ra;
            r_dec <= n_dec;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_ra_angle  = r_ra;
    assign o_dec_angle = r_dec;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_dec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dec_angle <= QUARTER && o_dec_angle >= NEG_QUARTER))
        else $error("declination outside +-90 degrees");

    a_stall_holds_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_p_valid) && $stable(w_v2[0]))
        else $error("pipeline advanced while output was held");

    a_ra_half_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v1[S] |-> !w_x1[S][DATA_W-1])
        else $error("RA pass left the right half-plane");

    a_axis_ra_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_v2[S] && w_f2[S].on_axis) |=> (o_ra_angle == '0))
        else $error("on-axis vector gave a nonzero RA");

endmodule
